// ===== design/qrs_pkg.sv =====
// Package with shared constants and types of the quadratic root solver.
package qrs_pkg;
    localparam int COEF_WIDTH = 16;
    localparam int FRAC_BITS  = 16;
    localparam int ROOT_WIDTH = 34;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
endpackage

// ===== design/qrs_if.sv =====
// Valid/ready channel interface with a generic payload width.
interface qrs_if #(parameter int W = 8) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/qrs_sqrt_stage.sv =====
// One registered stage of the restoring square root, NB result bits per stage.
module qrs_sqrt_stage #(
    parameter int RW = 40,
    parameter int NB = 4,
    parameter int PW = 40
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW-1:0] i_rem,
    input  logic [RW-1:0] i_root,
    input  logic [2*NB-1:0] i_pairs,
    input  logic [PW-1:0] i_pass,
    output logic [RW-1:0] o_rem,
    output logic [RW-1:0] o_root,
    output logic [PW-1:0] o_pass
);
    logic [RW-1:0] r_rem, r_root, n_rem, n_root;
    logic [PW-1:0] r_pass;

    always_comb begin
        logic [RW+1:0] rem;
        logic [RW+1:0] trial;
        n_rem  = i_rem;
        n_root = i_root;
        for (int k = NB - 1; k >= 0; k--) begin
            rem   = {n_rem, i_pairs[2*k +: 2]};
            trial = {n_root, 2'b01};
            if (rem >= trial) begin
                rem    = rem - trial;
                n_root = {n_root[RW-2:0], 1'b1};
            end else begin
                n_root = {n_root[RW-2:0], 1'b0};
            end
            n_rem = rem[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_pass <= i_pass;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_pass = r_pass;
endmodule

// ===== design/qrs_div_stage.sv =====
// One registered stage of a non-restoring-free unsigned long division, NB bits per stage.
module qrs_div_stage #(
    parameter int QW = 48,
    parameter int DW = 20,
    parameter int NB = 4,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_den,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_num,
    input  logic [PW-1:0] i_pass,
    output logic [DW-1:0] o_den,
    output logic [DW-1:0] o_rem,
    output logic [QW-1:0] o_num,
    output logic [PW-1:0] o_pass
);
    // The numerator register shifts out dividend bits at the top and takes
    // quotient bits at the bottom.
    logic [DW-1:0] r_den, r_rem, n_rem;
    logic [QW-1:0] r_num, n_num;
    logic [PW-1:0] r_pass;

    always_comb begin
        logic [DW:0] t;
        n_rem = i_rem;
        n_num = i_num;
        for (int k = 0; k < NB; k++) begin
            t = {n_rem, n_num[QW-1]};
            n_num = {n_num[QW-2:0], 1'b0};
            if (t >= {1'b0, i_den}) begin
                t = t - {1'b0, i_den};
                n_num[0] = 1'b1;
            end
            n_rem = t[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den  <= i_den;
            r_rem  <= n_rem;
            r_num  <= n_num;
            r_pass <= i_pass;
        end
    end

    assign o_den  = r_den;
    assign o_rem  = r_rem;
    assign o_num  = r_num;
    assign o_pass = r_pass;
endmodule

// ===== design/quadratic_root_solver_core.sv =====
// Top level of the pipelined quadratic root solver.
// The core accepts one coefficient request per cycle unless the output stalls
// and returns one result per request in order, through the product register,
// the discriminant register, nine square root stages, the numerator register,
// eighteen division stages (stage counts at default sizes) and the output
// register; each root or division stage resolves four bits. A single enable
// advances the whole pipeline, so a stall at the output freezes every stage and
// nothing is lost or repeated; the input is ready whenever the last stage is
// empty or being drained. The discriminant b*b - 4*a*c is exact, its square root is
// floor(sqrt(delta * 2^(2*FRAC_BITS))), and each root is
// (-b*2^FRAC_BITS -/+ s)/(2a) truncated toward zero and saturated to the root
// width. A zero coefficient a sets not_quadratic and reports no roots; a
// negative discriminant reports no roots with zero fields.
module quadratic_root_solver_core #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    qrs_if.sink   i_coef,
    qrs_if.source o_root
);
    localparam int RWID = qrs_pkg::ROOT_WIDTH;
    localparam int DLW  = 2 * COEF_WIDTH + 2;          // discriminant width, signed
    localparam int NB   = 4;
    localparam int SQB  = (DLW + 2 * FRAC_BITS + 1) / 2; // result bits of the root
    localparam int SQ_ST = (SQB + NB - 1) / NB;
    localparam int SQN  = SQ_ST * NB;
    localparam int RDW  = SQN + 2;                       // remainder/root register width
    localparam int NW   = SQN + COEF_WIDTH + FRAC_BITS + 2; // numerator magnitude width
    localparam int DVW  = COEF_WIDTH + 2;                // divisor width
    localparam int DV_ST = (NW + NB - 1) / NB;
    localparam int QW   = DV_ST * NB;
    // Width of the side information below: count, two flags, |a| and -b.
    localparam int PW   = 2 + 1 + 1 + COEF_WIDTH + COEF_WIDTH + 1;
    localparam int DEPTH = 4 + SQ_ST + DV_ST;

    typedef struct packed {
        logic [1:0]            cnt;
        logic                  nq;
        logic                  neg;   // a is negative
        logic [COEF_WIDTH-1:0] amag;
        logic signed [COEF_WIDTH:0] b;
    } t_side;

    logic [DEPTH-1:0] r_vld;
    logic             w_en;
    assign w_en = !r_vld[DEPTH-1] || o_root.ready;
    assign i_coef.ready = w_en;

    // Stage 1: products.
    logic signed [COEF_WIDTH-1:0] w_a, w_b, w_c;
    assign w_a = i_coef.data[3*COEF_WIDTH-1 -: COEF_WIDTH];
    assign w_b = i_coef.data[2*COEF_WIDTH-1 -: COEF_WIDTH];
    assign w_c = i_coef.data[COEF_WIDTH-1:0];
    logic signed [2*COEF_WIDTH-1:0] r_bb, r_ac;
    logic signed [COEF_WIDTH-1:0]   r_a1, r_b1;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bb <= w_b * w_b;
            r_ac <= w_a * w_c;
            r_a1 <= w_a;
            r_b1 <= w_b;
        end
    end

    // Stage 2: discriminant and classification.
    logic signed [DLW-1:0] w_dl;
    assign w_dl = DLW'(r_bb) - (DLW'(r_ac) <<< 2);
    logic [DLW-1:0] r_dl;
    t_side r_s2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl <= w_dl;
            r_s2.nq  <= (r_a1 == '0);
            r_s2.neg <= r_a1[COEF_WIDTH-1];
            r_s2.amag <= r_a1[COEF_WIDTH-1] ? COEF_WIDTH'(-r_a1) : COEF_WIDTH'(r_a1);
            r_s2.b <= -(COEF_WIDTH+1)'(r_b1);
            if (r_a1 == '0 || w_dl[DLW-1])
                r_s2.cnt <= qrs_pkg::CNT_NONE;
            else if (w_dl == '0)
                r_s2.cnt <= qrs_pkg::CNT_ONE;
            else
                r_s2.cnt <= qrs_pkg::CNT_TWO;
        end
    end

    // Square root chain over the scaled radicand, radicand padded to 2*SQN bits.
    logic [2*SQN-1:0] w_rad;
    assign w_rad = (2*SQN)'(r_dl[DLW-2:0]) << (2 * FRAC_BITS);
    logic [RDW-1:0]   sq_rem  [SQ_ST+1];
    logic [RDW-1:0]   sq_root [SQ_ST+1];
    logic [2*SQN+PW-1:0] sq_pass [SQ_ST+1];
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_pass[0] = {w_rad, r_s2};
    for (genvar g = 0; g < SQ_ST; g++) begin : g_sq
        qrs_sqrt_stage #(.RW(RDW), .NB(NB), .PW(2*SQN+PW)) u_sq (
            .i_clk(i_clk), .i_en(w_en), .i_rem(sq_rem[g]), .i_root(sq_root[g]),
            .i_pairs(sq_pass[g][PW + 2*SQN - 1 - 2*NB*g -: 2*NB]),
            .i_pass(sq_pass[g]), .o_rem(sq_rem[g+1]), .o_root(sq_root[g+1]),
            .o_pass(sq_pass[g+1]));
    end
    t_side w_s3;
    assign w_s3 = sq_pass[SQ_ST][PW-1:0];

    // Stage 3: signed numerators and their magnitudes, with the quotient sign.
    localparam int SW = NW + 1;
    logic signed [SW-1:0] w_nb, w_nlo, w_nhi;
    logic [SQN-1:0] w_s;
    assign w_s   = (w_s3.cnt == qrs_pkg::CNT_TWO) ? sq_root[SQ_ST][SQN-1:0] : '0;
    assign w_nb  = SW'(w_s3.b) <<< FRAC_BITS;
    assign w_nlo = w_nb - SW'({1'b0, w_s});
    assign w_nhi = w_nb + SW'({1'b0, w_s});
    logic [QW-1:0] r_mlo, r_mhi;
    logic r_sglo, r_sghi;
    t_side r_s4;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mlo  <= QW'(w_nlo[SW-1] ? NW'(-w_nlo) : NW'(w_nlo));
            r_mhi  <= QW'(w_nhi[SW-1] ? NW'(-w_nhi) : NW'(w_nhi));
            r_sglo <= w_nlo[SW-1] ^ w_s3.neg;
            r_sghi <= w_nhi[SW-1] ^ w_s3.neg;
            r_s4   <= w_s3;
        end
    end

    // Two division chains by |2a|.
    logic [DVW-1:0] w_den;
    assign w_den = DVW'({r_s4.amag, 1'b0});
    logic [DVW-1:0] dl_den [DV_ST+1], dl_rem [DV_ST+1], dh_den [DV_ST+1], dh_rem [DV_ST+1];
    logic [QW-1:0]  dl_num [DV_ST+1], dh_num [DV_ST+1];
    logic [PW:0]    dl_pass [DV_ST+1];
    logic           dh_pass [DV_ST+1];
    assign dl_den[0] = w_den;  assign dh_den[0] = w_den;
    assign dl_rem[0] = '0;     assign dh_rem[0] = '0;
    assign dl_num[0] = r_mlo;  assign dh_num[0] = r_mhi;
    assign dl_pass[0] = {r_sglo, r_s4};
    assign dh_pass[0] = r_sghi;
    for (genvar g = 0; g < DV_ST; g++) begin : g_dv
        qrs_div_stage #(.QW(QW), .DW(DVW), .NB(NB), .PW(PW+1)) u_lo (
            .i_clk(i_clk), .i_en(w_en), .i_den(dl_den[g]), .i_rem(dl_rem[g]),
            .i_num(dl_num[g]), .i_pass(dl_pass[g]), .o_den(dl_den[g+1]),
            .o_rem(dl_rem[g+1]), .o_num(dl_num[g+1]), .o_pass(dl_pass[g+1]));
        qrs_div_stage #(.QW(QW), .DW(DVW), .NB(NB), .PW(1)) u_hi (
            .i_clk(i_clk), .i_en(w_en), .i_den(dh_den[g]), .i_rem(dh_rem[g]),
            .i_num(dh_num[g]), .i_pass(dh_pass[g]), .o_den(dh_den[g+1]),
            .o_rem(dh_rem[g+1]), .o_num(dh_num[g+1]), .o_pass(dh_pass[g+1]));
    end
    t_side w_s5;
    assign w_s5 = dl_pass[DV_ST][PW-1:0];

    // Final stage: apply sign, saturate, zero out when there are no roots.
    localparam logic signed [QW+1:0] RMAX = (QW+2)'((64'sd1 <<< (RWID - 1)) - 1);
    localparam logic signed [QW+1:0] RMIN = -RMAX - 1;
    function automatic logic [RWID-1:0] f_pack(input logic [QW-1:0] m, input logic sg);
        logic signed [QW+1:0] q;
        q = sg ? -$signed({2'b00, m}) : $signed({2'b00, m});
        if (q > RMAX) q = RMAX;
        if (q < RMIN) q = RMIN;
        return q[RWID-1:0];
    endfunction
    logic [1:0] r_cnt;
    logic       r_nq;
    logic [RWID-1:0] r_lo, r_hi;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cnt <= w_s5.cnt;
            r_nq  <= w_s5.nq;
            r_lo  <= (w_s5.cnt == qrs_pkg::CNT_NONE) ? '0
                     : f_pack(dl_num[DV_ST], dl_pass[DV_ST][PW]);
            r_hi  <= (w_s5.cnt == qrs_pkg::CNT_NONE) ? '0
                     : f_pack(dh_num[DV_ST], dh_pass[DV_ST]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_coef.valid};
        end
    end

    assign o_root.valid = r_vld[DEPTH-1];
    assign o_root.data  = {r_cnt, r_lo, r_hi, r_nq};
endmodule

// ===== design/qrs_checker.sv =====
// Port-level checker for the quadratic root solver, bound to the top level.
module qrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [70:0] i_out_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed under stall");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data[70:69] != 2'd3)
        else $error("bad root count");
    a_nq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data[0]
        |-> i_out_data[70:69] == qrs_pkg::CNT_NONE && i_out_data[68:1] == '0)
        else $error("not quadratic with roots");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data[70:69] == qrs_pkg::CNT_ONE
        |-> i_out_data[68:35] == i_out_data[34:1])
        else $error("single root differs");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");
endmodule

bind quadratic_root_solver_core qrs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_ready(i_coef.ready),
    .i_out_valid(o_root.valid), .i_out_ready(o_root.ready), .i_out_data(o_root.data));
